/* sv/chte_pkg.sv */
// Package for the coalesced hash table engine: sizes, op and status codes,
// sequencer states and the store write bundle. Depends on nothing.
package chte_pkg;

    localparam int SLOTS    = 64;                       // power of two
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int LINK_W   = IDX_W + 1;                // signed relative link
    localparam int CNT_W    = IDX_W + 1;
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int HOME_MOD = (SLOTS - 1) | 1;          // 2**IDX_W - 1
    localparam int DIGITS   = (KEY_W + IDX_W - 1) / IDX_W;
    localparam int DIG_W    = $clog2(DIGITS + 1);

    localparam logic [1:0] OP_GET   = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_NIL    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_FIND_RD,
        S_FIND_CHK,
        S_FREE,
        S_MP_RD,
        S_MP_CHK,
        S_HASH2,
        S_WALK_RD,
        S_WALK_CHK,
        S_MOVE,
        S_HOME_WR,
        S_LINK_F,
        S_LINK_MP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                 key_en;
        logic                 val_en;
        logic                 link_en;
        logic [IDX_W-1:0]     addr;
        logic [KEY_W-1:0]     key;
        logic [VAL_W-1:0]     val;
        logic [LINK_W-1:0]    link;
    } store_wr_t;

endpackage

/* sv/coalesced_hash_table_engine.sv */
// Top level of the coalesced hash table engine: sequencer, slot flags,
// free cursor and result register. Depends on chte_pkg, chte_home, chte_store.
//
// A 64-slot scatter table for 64-bit keys with coalesced chains of relative
// links. One beat in gives one beat out (status, read value, present flag,
// occupancy). The block takes one operation at a time and holds in_stall high
// until its result is loaded into the output register; a waiting result does
// not block the next operation. A home slot is found in the shared
// digit-fold unit (key mod 63, six bits a cycle), and every chain probe goes
// through the registered read port of the slot store. An insert may also step
// the free cursor down past used slots, and a displaced entry needs a second
// fold plus a walk along its chain. Clear and the unused op code skip the
// fold. Clear drops the used and full flags at once; no sweep is needed.
module coalesced_hash_table_engine
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    op,
    input  logic signed [63:0]            key,
    input  logic [63:0]                   value,
    input  logic                          value_given,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [63:0]                   read_value,
    output logic                          read_present,
    output logic [6:0]                    occupancy
);

    localparam int IW = chte_pkg::IDX_W;
    localparam int LW = chte_pkg::LINK_W;
    localparam int CW = chte_pkg::CNT_W;

    chte_pkg::state_t state_reg, state_next;

    // latched operation
    logic [1:0]                  op_reg, op_next;
    logic [chte_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [chte_pkg::VAL_W-1:0]  val_reg, val_next;
    logic                        given_reg, given_next;

    // walk and insert state
    logic [IW-1:0]  home_reg, home_next;
    logic [IW-1:0]  node_reg, node_next;
    logic [IW-1:0]  free_reg, free_next;
    logic [CW-1:0]  steps_reg, steps_next;
    logic [CW-1:0]  cursor_reg, cursor_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           clr_link_reg, clr_link_next;
    logic [chte_pkg::KEY_W-1:0] mkey_reg, mkey_next;
    logic [chte_pkg::VAL_W-1:0] mval_reg, mval_next;
    logic [LW-1:0]              mlink_reg, mlink_next;

    // slot flags
    logic [chte_pkg::SLOTS-1:0] used_reg, used_next;
    logic [chte_pkg::SLOTS-1:0] full_reg, full_next;

    // pending result and output register
    logic [1:0]  rs_status_reg, rs_status_next;
    logic [63:0] rs_value_reg, rs_value_next;
    logic        rs_present_reg, rs_present_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [63:0] rv_reg, rv_next;
    logic        rp_reg, rp_next;
    logic [CW-1:0] occ_reg, occ_next;

    // shared units
    logic                       hash_start;
    logic [chte_pkg::KEY_W-1:0] hash_word;
    logic                       hash_done;
    logic [IW-1:0]              hash_res;
    chte_pkg::store_wr_t        wr;
    logic [IW-1:0]              rd_addr;
    logic [chte_pkg::KEY_W-1:0] key_q;
    logic [chte_pkg::VAL_W-1:0] val_q;
    logic [LW-1:0]              link_q;

    // chain follow from node_reg; links of unused slots read as zero
    logic [LW-1:0]   link_eff;
    logic [IW+1:0]   target;
    logic            follow_ok;
    logic            hit;
    logic            accept;
    logic            out_free;
    logic [CW-1:0]   cur_dec;
    logic [LW-1:0]   moved_link;

    assign accept   = in_valid && (state_reg == chte_pkg::S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign link_eff = used_reg[node_reg] ? link_q : '0;
    assign target   = {2'b00, node_reg} + {{2{link_eff[LW-1]}}, link_eff[LW-2:0]};
    assign follow_ok = (link_eff != '0) && (target[IW+1:IW] == 2'b00);
    assign hit      = used_reg[node_reg] && (key_q == key_reg);
    assign cur_dec  = cursor_reg - 1'b1;
    // link of the slot that takes over the home slot's chain position
    assign moved_link = (mlink_reg != '0)
                      ? LW'(mlink_reg + {1'b0, home_reg} - {1'b0, free_reg}) : '0;

    chte_home u_home
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .word   (hash_word),
        .done   (hash_done),
        .result (hash_res)
    );

    chte_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .key_q   (key_q),
        .val_q   (val_q),
        .link_q  (link_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            chte_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (op == chte_pkg::OP_GET || op == chte_pkg::OP_SET)
                    begin
                        state_next = chte_pkg::S_HASH;
                    end
                    else
                    begin
                        state_next = chte_pkg::S_DONE;
                    end
                end
            end
            chte_pkg::S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = chte_pkg::S_FIND_RD;
                end
            end
            chte_pkg::S_FIND_RD:  state_next = chte_pkg::S_FIND_CHK;
            chte_pkg::S_FIND_CHK:
            begin
                if (hit)
                begin
                    state_next = chte_pkg::S_DONE;
                end
                else if (follow_ok && steps_reg != CW'(chte_pkg::SLOTS - 1))
                begin
                    state_next = chte_pkg::S_FIND_RD;
                end
                else if (op_reg == chte_pkg::OP_GET || !given_reg)
                begin
                    state_next = chte_pkg::S_DONE;
                end
                else if (!full_reg[home_reg])
                begin
                    state_next = chte_pkg::S_HOME_WR;
                end
                else
                begin
                    state_next = chte_pkg::S_FREE;
                end
            end
            chte_pkg::S_FREE:
            begin
                if (cursor_reg == '0)
                begin
                    state_next = chte_pkg::S_DONE;
                end
                else if (!used_reg[cur_dec[IW-1:0]])
                begin
                    state_next = chte_pkg::S_MP_RD;
                end
            end
            chte_pkg::S_MP_RD:  state_next = chte_pkg::S_MP_CHK;
            chte_pkg::S_MP_CHK: state_next = chte_pkg::S_HASH2;
            chte_pkg::S_HASH2:
            begin
                if (hash_done)
                begin
                    state_next = (hash_res != home_reg) ? chte_pkg::S_WALK_RD
                                                        : chte_pkg::S_LINK_F;
                end
            end
            chte_pkg::S_WALK_RD: state_next = chte_pkg::S_WALK_CHK;
            chte_pkg::S_WALK_CHK:
            begin
                if (!follow_ok || target[IW-1:0] == home_reg
                    || steps_reg == CW'(chte_pkg::SLOTS - 1))
                begin
                    state_next = chte_pkg::S_MOVE;
                end
                else
                begin
                    state_next = chte_pkg::S_WALK_RD;
                end
            end
            chte_pkg::S_MOVE:    state_next = chte_pkg::S_HOME_WR;
            chte_pkg::S_HOME_WR: state_next = chte_pkg::S_DONE;
            chte_pkg::S_LINK_F:  state_next = chte_pkg::S_LINK_MP;
            chte_pkg::S_LINK_MP: state_next = chte_pkg::S_DONE;
            chte_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = chte_pkg::S_IDLE;
                end
            end
            default: state_next = chte_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        given_next      = given_reg;
        home_next       = home_reg;
        node_next       = node_reg;
        free_next       = free_reg;
        steps_next      = steps_reg;
        cursor_next     = cursor_reg;
        count_next      = count_reg;
        clr_link_next   = clr_link_reg;
        mkey_next       = mkey_reg;
        mval_next       = mval_reg;
        mlink_next      = mlink_reg;
        used_next       = used_reg;
        full_next       = full_reg;
        rs_status_next  = rs_status_reg;
        rs_value_next   = rs_value_reg;
        rs_present_next = rs_present_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        rv_next         = rv_reg;
        rp_next         = rp_reg;
        occ_next        = occ_reg;
        hash_start      = 1'b0;
        hash_word       = key;
        rd_addr         = node_reg;
        wr              = '0;

        // drop the output beat once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            chte_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = op;
                    key_next        = key;
                    val_next        = value;
                    given_next      = value_given;
                    rs_status_next  = chte_pkg::ST_OK;
                    rs_value_next   = '0;
                    rs_present_next = 1'b0;
                    if (op == chte_pkg::OP_GET || op == chte_pkg::OP_SET)
                    begin
                        hash_start = 1'b1;
                    end
                    else if (op == chte_pkg::OP_CLEAR)
                    begin
                        used_next   = '0;
                        full_next   = '0;
                        cursor_next = CW'(chte_pkg::SLOTS);
                        count_next  = '0;
                    end
                end
            end
            chte_pkg::S_HASH:
            begin
                if (hash_done)
                begin
                    home_next  = hash_res;
                    node_next  = hash_res;
                    steps_next = '0;
                end
            end
            chte_pkg::S_FIND_CHK:
            begin
                if (hit)
                begin
                    if (op_reg == chte_pkg::OP_GET)
                    begin
                        if (full_reg[node_reg])
                        begin
                            rs_value_next   = val_q;
                            rs_present_next = 1'b1;
                        end
                        else
                        begin
                            rs_status_next = chte_pkg::ST_ABSENT;
                        end
                    end
                    else
                    begin
                        if (full_reg[node_reg] && !given_reg)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        else if (!full_reg[node_reg] && given_reg)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        full_next[node_reg] = given_reg;
                        wr.val_en = 1'b1;
                        wr.addr   = node_reg;
                        wr.val    = val_reg;
                    end
                end
                else if (follow_ok && steps_reg != CW'(chte_pkg::SLOTS - 1))
                begin
                    node_next  = target[IW-1:0];
                    steps_next = steps_reg + 1'b1;
                end
                else if (op_reg == chte_pkg::OP_GET)
                begin
                    rs_status_next = chte_pkg::ST_ABSENT;
                end
                else if (!given_reg)
                begin
                    rs_status_next = chte_pkg::ST_NIL;
                end
                else
                begin
                    // fresh slot needs its link cleared
                    clr_link_next = !used_reg[home_reg];
                end
            end
            chte_pkg::S_FREE:
            begin
                if (cursor_reg == '0)
                begin
                    rs_status_next = chte_pkg::ST_FULL;
                end
                else
                begin
                    cursor_next = cur_dec;
                    free_next   = cur_dec[IW-1:0];
                end
            end
            chte_pkg::S_MP_RD:
            begin
                rd_addr = home_reg;
            end
            chte_pkg::S_MP_CHK:
            begin
                mkey_next  = key_q;
                mval_next  = val_q;
                mlink_next = link_q;
                hash_start = 1'b1;
                hash_word  = key_q;
            end
            chte_pkg::S_HASH2:
            begin
                if (hash_done)
                begin
                    node_next  = hash_res;
                    steps_next = '0;
                end
            end
            chte_pkg::S_WALK_CHK:
            begin
                if (follow_ok && target[IW-1:0] == home_reg)
                begin
                    // relink predecessor to the displaced entry's new slot
                    wr.link_en = 1'b1;
                    wr.addr    = node_reg;
                    wr.link    = LW'({1'b0, free_reg} - {1'b0, node_reg});
                end
                else if (follow_ok)
                begin
                    node_next  = target[IW-1:0];
                    steps_next = steps_reg + 1'b1;
                end
            end
            chte_pkg::S_MOVE:
            begin
                wr.key_en  = 1'b1;
                wr.val_en  = 1'b1;
                wr.link_en = 1'b1;
                wr.addr    = free_reg;
                wr.key     = mkey_reg;
                wr.val     = mval_reg;
                wr.link    = moved_link;
                used_next[free_reg] = 1'b1;
                full_next[free_reg] = 1'b1;
                clr_link_next       = 1'b1;
            end
            chte_pkg::S_HOME_WR:
            begin
                wr.key_en  = 1'b1;
                wr.val_en  = 1'b1;
                wr.link_en = clr_link_reg;
                wr.addr    = home_reg;
                wr.key     = key_reg;
                wr.val     = val_reg;
                wr.link    = '0;
                used_next[home_reg] = 1'b1;
                full_next[home_reg] = 1'b1;
                count_next          = count_reg + 1'b1;
            end
            chte_pkg::S_LINK_F:
            begin
                wr.key_en  = 1'b1;
                wr.val_en  = 1'b1;
                wr.link_en = 1'b1;
                wr.addr    = free_reg;
                wr.key     = key_reg;
                wr.val     = val_reg;
                wr.link    = moved_link;
                used_next[free_reg] = 1'b1;
                full_next[free_reg] = 1'b1;
            end
            chte_pkg::S_LINK_MP:
            begin
                wr.link_en = 1'b1;
                wr.addr    = home_reg;
                wr.link    = LW'({1'b0, free_reg} - {1'b0, home_reg});
                count_next = count_reg + 1'b1;
            end
            chte_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = rs_status_reg;
                    rv_next        = rs_value_reg;
                    rp_next        = rs_present_reg;
                    occ_next       = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chte_pkg::S_IDLE;
            used_reg      <= '0;
            full_reg      <= '0;
            cursor_reg    <= CW'(chte_pkg::SLOTS);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            full_reg      <= full_next;
            cursor_reg    <= cursor_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        given_reg      <= given_next;
        home_reg       <= home_next;
        node_reg       <= node_next;
        free_reg       <= free_next;
        steps_reg      <= steps_next;
        clr_link_reg   <= clr_link_next;
        mkey_reg       <= mkey_next;
        mval_reg       <= mval_next;
        mlink_reg      <= mlink_next;
        rs_status_reg  <= rs_status_next;
        rs_value_reg   <= rs_value_next;
        rs_present_reg <= rs_present_next;
        status_reg     <= status_next;
        rv_reg         <= rv_next;
        rp_reg         <= rp_next;
        occ_reg        <= occ_next;
    end

    assign in_stall     = (state_reg != chte_pkg::S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign read_value   = rv_reg;
    assign read_present = rp_reg;
    assign occupancy    = occ_reg;

endmodule

/* sv/chte_home.sv */
// Home slot unit: key modulo (2**IDX_W - 1) by folding one IDX_W-bit digit
// per cycle. Depends on chte_pkg.
module chte_home
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [chte_pkg::KEY_W-1:0]  word,
    output logic                        done,
    output logic [chte_pkg::IDX_W-1:0]  result
);

    logic [chte_pkg::KEY_W-1:0] sh_reg, sh_next;
    logic [chte_pkg::IDX_W-1:0] acc_reg, acc_next;
    logic [chte_pkg::DIG_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [chte_pkg::IDX_W:0]   sum;

    always_comb
    begin
        sum = {1'b0, acc_reg} + {1'b0, sh_reg[chte_pkg::IDX_W-1:0]};
        if (sum >= (chte_pkg::IDX_W+1)'(chte_pkg::HOME_MOD))
        begin
            sum = sum - (chte_pkg::IDX_W+1)'(chte_pkg::HOME_MOD);
        end
    end

    assign done   = busy_reg && (cnt_reg == '0);
    // all ones is congruent to zero
    assign result = (acc_reg == chte_pkg::IDX_W'(chte_pkg::HOME_MOD)) ? '0 : acc_reg;

    always_comb
    begin
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            sh_next   = word;
            acc_next  = '0;
            cnt_next  = chte_pkg::DIG_W'(chte_pkg::DIGITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                acc_next = sum[chte_pkg::IDX_W-1:0];
                sh_next  = sh_reg >> chte_pkg::IDX_W;
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

endmodule

/* sv/chte_store.sv */
// Slot store: key, value and link memories with one write port and one
// registered read port. Depends on chte_pkg.
module chte_store
(
    input  logic                         clk,
    input  chte_pkg::store_wr_t          wr,
    input  logic [chte_pkg::IDX_W-1:0]   rd_addr,
    output logic [chte_pkg::KEY_W-1:0]   key_q,
    output logic [chte_pkg::VAL_W-1:0]   val_q,
    output logic [chte_pkg::LINK_W-1:0]  link_q
);

    logic [chte_pkg::KEY_W-1:0]  key_mem  [chte_pkg::SLOTS];
    logic [chte_pkg::VAL_W-1:0]  val_mem  [chte_pkg::SLOTS];
    logic [chte_pkg::LINK_W-1:0] link_mem [chte_pkg::SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.key_en)
        begin
            key_mem[wr.addr] <= wr.key;
        end
        if (wr.val_en)
        begin
            val_mem[wr.addr] <= wr.val;
        end
        if (wr.link_en)
        begin
            link_mem[wr.addr] <= wr.link;
        end
        key_q  <= key_mem[rd_addr];
        val_q  <= val_mem[rd_addr];
        link_q <= link_mem[rd_addr];
    end

endmodule

/* tb/sv/chte_scoreboard.sv */
`timescale 1ns / 100ps
// Scoreboard for the coalesced hash table engine: watches both channels,
// keeps its own slot table and compares every result beat. Depends on chte_pkg.
module chte_scoreboard
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [1:0]          op,
    input  logic signed [63:0]  key,
    input  logic [63:0]         value,
    input  logic                value_given,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [1:0]          status,
    input  logic [63:0]         read_value,
    input  logic                read_present,
    input  logic [6:0]          occupancy,
    output int                  errors,
    output int                  pending,
    output int                  full_hits,
    output int                  displaced
);

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] read_value;
        logic        read_present;
        logic [6:0]  occupancy;
    } answer_t;

    answer_t     answers[$];
    logic [63:0] tab_key[chte_pkg::SLOTS];
    bit          tab_used[chte_pkg::SLOTS];
    logic [63:0] tab_val[chte_pkg::SLOTS];
    bit          tab_full[chte_pkg::SLOTS];
    int          tab_link[chte_pkg::SLOTS];
    int          cursor;
    int          filled;

    assign pending = answers.size();

    function automatic void wipe_table();
        for (int i = 0; i < chte_pkg::SLOTS; i++)
        begin
            tab_used[i] = 0;
            tab_full[i] = 0;
            tab_link[i] = 0;
            tab_key[i]  = '0;
            tab_val[i]  = '0;
        end
        cursor = chte_pkg::SLOTS;
        filled = 0;
    endfunction

    function automatic int home_slot(logic [63:0] k);
        return int'(k % 64'(chte_pkg::HOME_MOD));
    endfunction

    // Follow a relative link; a zero link or one that leaves the store ends the chain.
    function automatic bit hop(int n, output int t);
        t = n + tab_link[n];
        return tab_link[n] != 0 && t >= 0 && t < chte_pkg::SLOTS;
    endfunction

    function automatic int locate(logic [63:0] k);
        int n;
        int t;
        n = home_slot(k);
        for (int s = 0; s < chte_pkg::SLOTS; s++)
        begin
            if (tab_used[n] && tab_key[n] == k)
                return n;
            if (!hop(n, t))
                return -1;
            n = t;
        end
        return -1;
    endfunction

    function automatic int grab_free();
        while (cursor > 0)
        begin
            cursor--;
            if (!tab_used[cursor])
                return cursor;
        end
        return -1;
    endfunction

    function automatic bit place_new(logic [63:0] k, logic [63:0] v);
        int mp;
        int f;
        int other;
        int prev;
        int nx;
        mp = home_slot(k);
        if (tab_full[mp])
        begin
            f = grab_free();
            if (f < 0)
                return 0;
            other = home_slot(tab_key[mp]);
            if (other != mp)
            begin
                // Evict the squatter: relink its predecessor to the free slot.
                displaced++;
                prev = other;
                for (int s = 0; s < chte_pkg::SLOTS; s++)
                begin
                    if (!hop(prev, nx))
                        break;
                    if (nx == mp)
                    begin
                        tab_link[prev] = f - prev;
                        break;
                    end
                    prev = nx;
                end
                tab_key[f]  = tab_key[mp];
                tab_used[f] = tab_used[mp];
                tab_val[f]  = tab_val[mp];
                tab_full[f] = tab_full[mp];
                tab_link[f] = tab_link[mp];
                if (tab_link[mp] != 0)
                begin
                    tab_link[f] += mp - f;
                    tab_link[mp] = 0;
                end
                tab_full[mp] = 0;
            end
            else
            begin
                tab_link[f] = (tab_link[mp] != 0) ? mp + tab_link[mp] - f : 0;
                tab_link[mp] = f - mp;
                mp = f;
            end
        end
        tab_key[mp]  = k;
        tab_used[mp] = 1;
        tab_val[mp]  = v;
        tab_full[mp] = 1;
        return 1;
    endfunction

    function automatic answer_t apply_op(logic [1:0] o, logic [63:0] k, logic [63:0] v,
                                         logic g);
        answer_t a;
        int n;
        a = '0;
        if (o == chte_pkg::OP_GET)
        begin
            n = locate(k);
            if (n >= 0 && tab_full[n])
            begin
                a.read_value   = tab_val[n];
                a.read_present = 1'b1;
            end
            else
                a.status = chte_pkg::ST_ABSENT;
        end
        else if (o == chte_pkg::OP_SET)
        begin
            n = locate(k);
            if (n >= 0)
            begin
                if (tab_full[n] && !g)
                    filled--;
                else if (!tab_full[n] && g)
                    filled++;
                tab_full[n] = g;
                tab_val[n]  = g ? v : '0;
            end
            else if (!g)
                a.status = chte_pkg::ST_NIL;
            else if (place_new(k, v))
                filled++;
            else
            begin
                a.status = chte_pkg::ST_FULL;
                full_hits++;
            end
        end
        else if (o == chte_pkg::OP_CLEAR)
            wipe_table();
        a.occupancy = 7'(filled);
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            wipe_table();
            answers.delete();
            errors    = 0;
            full_hits = 0;
            displaced = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (answers.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    want = answers.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors++;
                    end
                    if (read_value !== want.read_value)
                    begin
                        $error("read_value: expected %h, got %h", want.read_value,
                               read_value);
                        errors++;
                    end
                    if (read_present !== want.read_present)
                    begin
                        $error("read_present: expected %0d, got %0d", want.read_present,
                               read_present);
                        errors++;
                    end
                    if (occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d", want.occupancy,
                               occupancy);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                answers.push_back(apply_op(op, key, value, value_given));
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Top of the hash table engine testbench: clock, reset, operation stimulus
// and verdict. Depends on chte_pkg, chte_scoreboard and the engine RTL.
module testbench;

    // The op field's fourth code has no name in the package; the block ignores it.
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         POOL = 110;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         op = chte_pkg::OP_GET;
    logic signed [63:0] key = '0;
    logic [63:0]        value = '0;
    logic               value_given = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic [63:0]        read_value;
    logic               read_present;
    logic [6:0]         occupancy;

    int          errors;
    int          pending;
    int          full_hits;
    int          displaced;
    int          cycles = 0;
    int          burst_left = 0;
    int          sent[4];
    logic [63:0] key_pool[POOL];

    always #5 clk = ~clk;

    coalesced_hash_table_engine dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .key(key), .value(value), .value_given(value_given),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .read_value(read_value),
        .read_present(read_present), .occupancy(occupancy)
    );

    chte_scoreboard checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .key(key), .value(value), .value_given(value_given),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .read_value(read_value),
        .read_present(read_present), .occupancy(occupancy),
        .errors(errors), .pending(pending),
        .full_hits(full_hits), .displaced(displaced)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side backpressure: step through four stall modes in turn so that
    // free-flowing stretches, random stalls and long holds all occur.
    always @(negedge clk)
    begin
        int mode;
        mode = (cycles / 256) % 4;
        case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            2: out_stall <= ((cycles % 37) < 20);
            default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // Present one beat and hold it until taken; then maybe open a gap.
    task automatic issue(logic [1:0] o, logic [63:0] k, logic [63:0] v, logic g);
        @(negedge clk);
        op          = o;
        key         = k;
        value       = v;
        value_given = g;
        in_valid    = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent[o]++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 6))
                @(negedge clk);
        end
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [63:0] any_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        logic [1:0]  o;
        int          pick;
        sent = '{default: 0};

        // Key pool: many keys share a few home slots so chains grow long,
        // plus wide random keys and the signed extremes.
        for (int i = 0; i < POOL; i++)
        begin
            if (i < 50)
                key_pool[i] = 64'(chte_pkg::HOME_MOD) * $urandom_range(0, 40)
                              + $urandom_range(0, 7);
            else
                key_pool[i] = {$urandom, $urandom};
        end
        key_pool[50] = 64'h8000_0000_0000_0000;
        key_pool[51] = 64'h7fff_ffff_ffff_ffff;
        key_pool[52] = '1;

        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty lookups, extremes, nil handling and collisions.
        issue(chte_pkg::OP_GET, 64'd0, '0, 1'b0);
        issue(chte_pkg::OP_SET, 64'd5, 64'hffff_ffff_ffff_ffff, 1'b0);
        issue(chte_pkg::OP_SET, 64'h8000_0000_0000_0000, '1, 1'b1);
        issue(chte_pkg::OP_SET, 64'h7fff_ffff_ffff_ffff, '0, 1'b1);
        issue(chte_pkg::OP_SET, '1, 64'h0123_4567_89ab_cdef, 1'b1);
        issue(chte_pkg::OP_GET, 64'h8000_0000_0000_0000, '0, 1'b0);
        issue(chte_pkg::OP_GET, '1, '0, 1'b1);
        issue(chte_pkg::OP_SET, 64'd68, 64'd111, 1'b1);
        issue(chte_pkg::OP_SET, 64'd5, 64'd222, 1'b1);
        issue(chte_pkg::OP_SET, 64'd131, 64'd333, 1'b1);
        issue(chte_pkg::OP_GET, 64'd68, '0, 1'b0);
        issue(chte_pkg::OP_GET, 64'd131, '0, 1'b0);
        issue(chte_pkg::OP_SET, 64'd5, 64'd444, 1'b1);
        issue(chte_pkg::OP_SET, 64'd68, '0, 1'b0);
        issue(chte_pkg::OP_GET, 64'd68, '0, 1'b0);
        issue(chte_pkg::OP_SET, 64'd68, 64'd555, 1'b1);
        issue(OP_NOP, 64'd5, '1, 1'b1);
        issue(chte_pkg::OP_GET, 64'd194, '0, 1'b0);
        drain();
        issue(chte_pkg::OP_CLEAR, '0, '0, 1'b0);
        issue(chte_pkg::OP_GET, 64'd5, '0, 1'b0);

        // Random: mostly pool keys so the table fills, chains and overflows.
        for (int n = 0; n < 700; n++)
        begin
            pick = $urandom_range(0, 199);
            if (pick < 80)
                o = chte_pkg::OP_GET;
            else if (pick < 196)
                o = chte_pkg::OP_SET;
            else if (pick < 198)
                o = chte_pkg::OP_CLEAR;
            else
                o = OP_NOP;
            issue(o, ($urandom_range(0, 9) < 9) ? key_pool[$urandom_range(0, POOL - 1)]
                                                 : any_word(),
                  any_word(), ($urandom_range(0, 7) != 0));
            if (n % 175 == 100)
                drain();
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);

        $display("Covered %0d gets, %0d sets, %0d clears, %0d idle ops;",
                 sent[chte_pkg::OP_GET], sent[chte_pkg::OP_SET],
                 sent[chte_pkg::OP_CLEAR], sent[OP_NOP]);
        $display("  %0d evictions of misplaced entries, %0d sets refused on a full table.",
                 displaced, full_hits);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
sv/chte_pkg.sv
sv/chte_home.sv
sv/chte_store.sv
sv/coalesced_hash_table_engine.sv
tb/sv/chte_scoreboard.sv
tb/sv/testbench.sv
